// ===== hw/rtl/gha_pkg.sv =====
package gha_pkg;

  localparam int unsigned DEF_INDEX_BITS = 10;
  localparam int unsigned DEF_GEN_BITS   = 8;
  localparam int unsigned DEF_FLAG_BITS  = 8;

  localparam int unsigned CMD_BITS = 3;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_CREATE  = 3'd0,
    CMD_DESTROY = 3'd1,
    CMD_CHECK   = 3'd2,
    CMD_TEST    = 3'd3,
    CMD_SET     = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_WIPE    = 3'd6
  } gha_cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } gha_state_e;

  typedef struct packed {
    logic we;
    logic ok;
  } gha_ctl_t;

endpackage

// ===== hw/rtl/gha_if.sv =====
interface gha_req_if #(
  parameter int unsigned INDEX_BITS = gha_pkg::DEF_INDEX_BITS,
  parameter int unsigned GEN_BITS   = gha_pkg::DEF_GEN_BITS,
  parameter int unsigned FLAG_BITS  = gha_pkg::DEF_FLAG_BITS
);
  logic                         valid;
  logic                         ready;
  logic [gha_pkg::CMD_BITS-1:0] cmd;
  logic [INDEX_BITS-1:0]        handle_index;
  logic [GEN_BITS-1:0]          handle_generation;
  logic [FLAG_BITS-1:0]         flag_mask;

  modport source (output valid, cmd, handle_index, handle_generation, flag_mask,
                  input ready);
  modport sink   (input valid, cmd, handle_index, handle_generation, flag_mask,
                  output ready);
endinterface

interface gha_rsp_if #(
  parameter int unsigned INDEX_BITS = gha_pkg::DEF_INDEX_BITS,
  parameter int unsigned GEN_BITS   = gha_pkg::DEF_GEN_BITS,
  parameter int unsigned FLAG_BITS  = gha_pkg::DEF_FLAG_BITS
);
  logic                  valid;
  logic                  ready;
  logic                  ok;
  logic [INDEX_BITS-1:0] out_index;
  logic [GEN_BITS-1:0]   out_generation;
  logic [FLAG_BITS-1:0]  out_flags;
  logic [INDEX_BITS-1:0] alive_count;

  modport source (output valid, ok, out_index, out_generation, out_flags, alive_count,
                  input ready);
  modport sink   (input valid, ok, out_index, out_generation, out_flags, alive_count,
                  output ready);
endinterface

// ===== hw/rtl/gha_ram.sv =====
module gha_ram #(
  parameter int unsigned Width = 26,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/gha_exec.sv =====
module gha_exec #(
  parameter int unsigned INDEX_BITS = gha_pkg::DEF_INDEX_BITS,
  parameter int unsigned GEN_BITS   = gha_pkg::DEF_GEN_BITS,
  parameter int unsigned FLAG_BITS  = gha_pkg::DEF_FLAG_BITS,
  localparam int unsigned EntryBits = INDEX_BITS + GEN_BITS + FLAG_BITS
) (
  input  logic [gha_pkg::CMD_BITS-1:0] cmd_i,
  input  logic [INDEX_BITS-1:0]        idx_i,
  input  logic [GEN_BITS-1:0]          gen_i,
  input  logic [FLAG_BITS-1:0]         mask_i,
  input  logic [EntryBits-1:0]         entry_i,
  input  logic [INDEX_BITS-1:0]        free_head_i,
  input  logic [INDEX_BITS-1:0]        high_water_i,
  input  logic [INDEX_BITS-1:0]        alive_i,
  output gha_pkg::gha_ctl_t            ctl_o,
  output logic [INDEX_BITS-1:0]        wr_addr_o,
  output logic [EntryBits-1:0]         wr_data_o,
  output logic [INDEX_BITS-1:0]        free_head_o,
  output logic [INDEX_BITS-1:0]        high_water_o,
  output logic [INDEX_BITS-1:0]        alive_o,
  output logic [INDEX_BITS-1:0]        out_index_o,
  output logic [GEN_BITS-1:0]          out_gen_o,
  output logic [FLAG_BITS-1:0]         out_flags_o
);

  localparam logic [INDEX_BITS-1:0] IdxMax  = '1;
  localparam logic [GEN_BITS-1:0]   GenMax  = '1;
  localparam logic [GEN_BITS-1:0]   GenLast = GenMax - GEN_BITS'(1);
  localparam logic [FLAG_BITS-1:0]  Active  = FLAG_BITS'(1);

  logic [INDEX_BITS-1:0] e_link;
  logic [GEN_BITS-1:0]   e_gen;
  logic [FLAG_BITS-1:0]  e_flags;
  logic                  used;
  logic                  valid;
  logic [GEN_BITS-1:0]   next_gen;
  logic [FLAG_BITS-1:0]  new_flags;
  logic [INDEX_BITS-1:0] alive_up;
  logic [INDEX_BITS-1:0] alive_down;

  assign e_link   = entry_i[INDEX_BITS-1:0];
  assign e_gen    = entry_i[INDEX_BITS +: GEN_BITS];
  assign e_flags  = entry_i[INDEX_BITS+GEN_BITS +: FLAG_BITS];
  assign used     = idx_i < high_water_i;
  assign valid    = (gen_i != GenMax) && (gen_i == e_gen);
  assign next_gen = gen_i + GEN_BITS'(1);

  assign alive_up   = (alive_i != IdxMax) ? alive_i + INDEX_BITS'(1) : alive_i;
  assign alive_down = (alive_i != '0) ? alive_i - INDEX_BITS'(1) : alive_i;

  always_comb begin
    unique case (cmd_i)
      gha_pkg::CMD_SET:   new_flags = e_flags | mask_i;
      gha_pkg::CMD_CLEAR: new_flags = e_flags & ~mask_i;
      default:            new_flags = '0;
    endcase
  end

  always_comb begin
    ctl_o        = '0;
    wr_addr_o    = idx_i;
    wr_data_o    = entry_i;
    free_head_o  = free_head_i;
    high_water_o = high_water_i;
    alive_o      = alive_i;
    out_index_o  = '0;
    out_gen_o    = '0;
    out_flags_o  = '0;
    unique case (cmd_i)
      gha_pkg::CMD_CREATE: begin
        if (free_head_i != IdxMax) begin
          ctl_o.we    = 1'b1;
          ctl_o.ok    = 1'b1;
          wr_addr_o   = free_head_i;
          wr_data_o   = {Active, e_gen, free_head_i};
          free_head_o = e_link;
          alive_o     = alive_up;
          out_index_o = free_head_i;
          out_gen_o   = e_gen;
          out_flags_o = Active;
        end else if (high_water_i != IdxMax) begin
          ctl_o.we     = 1'b1;
          ctl_o.ok     = 1'b1;
          wr_addr_o    = high_water_i;
          wr_data_o    = {Active, {GEN_BITS{1'b0}}, high_water_i};
          high_water_o = high_water_i + INDEX_BITS'(1);
          alive_o      = alive_up;
          out_index_o  = high_water_i;
          out_flags_o  = Active;
        end
      end
      gha_pkg::CMD_DESTROY: begin
        out_index_o = idx_i;
        if (used) begin
          out_gen_o   = e_gen;
          out_flags_o = e_flags;
          if (valid) begin
            ctl_o.we = 1'b1;
            ctl_o.ok = 1'b1;
            alive_o  = alive_down;
            out_flags_o = '0;
            if (gen_i != GenLast) begin
              wr_data_o   = {{FLAG_BITS{1'b0}}, next_gen, free_head_i};
              free_head_o = idx_i;
              out_gen_o   = next_gen;
            end else begin
              wr_data_o = {{FLAG_BITS{1'b0}}, GenMax, idx_i};
              out_gen_o = GenMax;
            end
          end
        end
      end
      gha_pkg::CMD_CHECK: begin
        out_index_o = idx_i;
        if (used) begin
          ctl_o.ok    = valid;
          out_gen_o   = e_gen;
          out_flags_o = e_flags;
        end
      end
      gha_pkg::CMD_TEST: begin
        out_index_o = idx_i;
        if (used) begin
          ctl_o.ok    = |(e_flags & mask_i);
          out_gen_o   = e_gen;
          out_flags_o = e_flags;
        end
      end
      gha_pkg::CMD_SET, gha_pkg::CMD_CLEAR, gha_pkg::CMD_WIPE: begin
        out_index_o = idx_i;
        if (used) begin
          ctl_o.we    = 1'b1;
          ctl_o.ok    = 1'b1;
          wr_data_o   = {new_flags, e_gen, e_link};
          out_gen_o   = e_gen;
          out_flags_o = new_flags;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/generational_handle_allocator.sv =====
// Channel | Dir | Beat
// req_i   | in  | cmd, handle_index, handle_generation, flag_mask
// rsp_o   | out | ok, out_index, out_generation, out_flags, alive_count
//
// Each request is handled in two steps: the slot table is read (a registered read) when
// it is taken, then the entry is modified and written back and the response registered.
// Reset empties the free list and clears the high-water mark and alive count;
// the table is not cleared, as a slot's contents are only used once it has been written.
// A new request is taken while a response waits; it stalls in the write-back
// cycle until the held response beat has gone.
module generational_handle_allocator #(
  parameter int unsigned INDEX_BITS = gha_pkg::DEF_INDEX_BITS,
  parameter int unsigned GEN_BITS   = gha_pkg::DEF_GEN_BITS,
  parameter int unsigned FLAG_BITS  = gha_pkg::DEF_FLAG_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  gha_req_if.sink   req_i,
  gha_rsp_if.source rsp_o
);

  localparam int unsigned EntryBits = INDEX_BITS + GEN_BITS + FLAG_BITS;
  localparam int unsigned Depth     = 2 ** INDEX_BITS;

  gha_pkg::gha_state_e state_q, state_d;

  logic [gha_pkg::CMD_BITS-1:0] cmd_q;
  logic [INDEX_BITS-1:0]        idx_q;
  logic [GEN_BITS-1:0]          gen_q;
  logic [FLAG_BITS-1:0]         mask_q;

  logic [INDEX_BITS-1:0] free_head_q, free_head_d;
  logic [INDEX_BITS-1:0] high_water_q, high_water_d;
  logic [INDEX_BITS-1:0] alive_q, alive_d;

  logic                  rsp_valid_q;
  logic                  rsp_ok_q;
  logic [INDEX_BITS-1:0] rsp_index_q;
  logic [GEN_BITS-1:0]   rsp_gen_q;
  logic [FLAG_BITS-1:0]  rsp_flags_q;

  logic                  accept;
  logic                  done;
  logic [INDEX_BITS-1:0] raddr;
  logic [EntryBits-1:0]  rdata;

  gha_pkg::gha_ctl_t     ctl;
  logic [INDEX_BITS-1:0] wr_addr;
  logic [EntryBits-1:0]  wr_data;
  logic [INDEX_BITS-1:0] ex_index;
  logic [GEN_BITS-1:0]   ex_gen;
  logic [FLAG_BITS-1:0]  ex_flags;

  assign req_i.ready = (state_q == gha_pkg::ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign done        = (state_q == gha_pkg::ST_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign raddr = (req_i.cmd == gha_pkg::CMD_CREATE) ? free_head_q : req_i.handle_index;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gha_pkg::ST_IDLE: if (accept) state_d = gha_pkg::ST_EXEC;
      gha_pkg::ST_EXEC: if (done) state_d = gha_pkg::ST_IDLE;
      default:          state_d = gha_pkg::ST_IDLE;
    endcase
  end

  gha_ram #(
    .Width (EntryBits),
    .Depth (Depth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (done && ctl.we),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  gha_exec #(
    .INDEX_BITS (INDEX_BITS),
    .GEN_BITS   (GEN_BITS),
    .FLAG_BITS  (FLAG_BITS)
  ) u_exec (
    .cmd_i        (cmd_q),
    .idx_i        (idx_q),
    .gen_i        (gen_q),
    .mask_i       (mask_q),
    .entry_i      (rdata),
    .free_head_i  (free_head_q),
    .high_water_i (high_water_q),
    .alive_i      (alive_q),
    .ctl_o        (ctl),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .free_head_o  (free_head_d),
    .high_water_o (high_water_d),
    .alive_o      (alive_d),
    .out_index_o  (ex_index),
    .out_gen_o    (ex_gen),
    .out_flags_o  (ex_flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gha_pkg::ST_IDLE;
      free_head_q  <= '1;
      high_water_q <= '0;
      alive_q      <= '0;
      rsp_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done) begin
        free_head_q  <= free_head_d;
        high_water_q <= high_water_d;
        alive_q      <= alive_d;
        rsp_valid_q  <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_i.cmd;
      idx_q  <= req_i.handle_index;
      gen_q  <= req_i.handle_generation;
      mask_q <= req_i.flag_mask;
    end
    if (done) begin
      rsp_ok_q    <= ctl.ok;
      rsp_index_q <= ex_index;
      rsp_gen_q   <= ex_gen;
      rsp_flags_q <= ex_flags;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.ok             = rsp_ok_q;
  assign rsp_o.out_index      = rsp_index_q;
  assign rsp_o.out_generation = rsp_gen_q;
  assign rsp_o.out_flags      = rsp_flags_q;
  assign rsp_o.alive_count    = alive_q;

endmodule
